>>> rtl/ilsr_pkg.sv
// ----------------------------------------------------------------------------
// ilsr_pkg
// Shared widths, constants and types of the index linked set removal block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilsr_pkg;

  localparam int MAX_INDICES = 1024;
  localparam int IDX_W       = $clog2(MAX_INDICES);
  localparam int LINK_W      = 11;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;
  localparam logic [LINK_W-1:0] COUNT_MAX = LINK_W'(MAX_INDICES);

  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] addr;
  } clr_t;

endpackage

`default_nettype wire

>>> rtl/ilsr_link_mem.sv
// ----------------------------------------------------------------------------
// ilsr_link_mem
// One link table: a single write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ilsr_link_mem
  import ilsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [LINK_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [MAX_INDICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ilsr_clear.sv
// ----------------------------------------------------------------------------
// ilsr_clear
// Address sweep that rebuilds both link tables to the full chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ilsr_clear
  import ilsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output clr_t      clr
);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      clr.active <= 1'b1;
      clr.addr   <= '0;
    end else if (clr.active) begin
      clr.addr <= clr.addr + 1'b1;
      if (clr.addr == IDX_W'(MAX_INDICES - 1)) begin
        clr.active <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/index_linked_set_removal.sv
// ----------------------------------------------------------------------------
// index_linked_set_removal
// Removes indices from a set kept as a doubly linked list in two link tables.
//
//   Port group      Dir  Item contents
//   s_axis_*        in   remove_index
//   m_axis_*        out  lowest_present, set_empty, index_invalid
//   cfg_wen/wdata   in   index_count
//
// An item passes through three steps: accept, link read, then the update and
// the result load; no new item is accepted until the update is done.
// After reset and after every write of index_count, a rebuild sweep writes
// all 1024 table entries, one per cycle, and no item is accepted meanwhile.
// Reset is synchronous and active high. A result that is not taken holds
// the update step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module index_linked_set_removal
  import ilsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] remove_index
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [M_TDATA_W-1:0] m_axis_tdata,   // [10:0] lowest_present,
                                                    // [11] set_empty,
                                                    // [12] index_invalid
  input  wire logic                 cfg_wen,
  input  wire logic [LINK_W-1:0]    cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t            state;
  clr_t              clr;
  logic [LINK_W-1:0] index_count;
  logic [LINK_W-1:0] lowest;
  logic [LINK_W-1:0] lowest_next;
  logic [IDX_W-1:0]  rm_index;
  logic              rm_invalid;
  logic [LINK_W-1:0] pred;
  logic [LINK_W-1:0] succ;
  logic              upd_go;
  logic              upd_prev_we;
  logic              upd_next_we;
  logic              prev_we;
  logic              next_we;
  logic [IDX_W-1:0]  prev_waddr;
  logic [IDX_W-1:0]  next_waddr;
  logic [LINK_W-1:0] prev_wdata;
  logic [LINK_W-1:0] next_wdata;
  logic              rd_en;

  assign s_axis_tready = (state == ST_IDLE) && !clr.active;
  assign upd_go        = (state == ST_UPDATE) && (!m_axis_tvalid || m_axis_tready);
  assign rd_en         = (state == ST_READ);

  ilsr_clear u_clear (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wen),
    .clr   (clr)
  );

  always_comb begin
    lowest_next = lowest;
    upd_prev_we = 1'b0;
    upd_next_we = 1'b0;
    if (!rm_invalid) begin
      if ({1'b0, rm_index} == lowest) begin
        lowest_next = succ;
        upd_prev_we = succ < index_count;
      end else begin
        upd_next_we = pred < index_count;
        upd_prev_we = succ < index_count;
      end
    end
  end

  always_comb begin
    if (clr.active) begin
      prev_we    = 1'b1;
      next_we    = 1'b1;
      prev_waddr = clr.addr;
      next_waddr = clr.addr;
      prev_wdata = (clr.addr == '0) ? LINK_NONE : LINK_W'(clr.addr) - 1'b1;
      next_wdata = LINK_W'(clr.addr) + 1'b1;
    end else begin
      prev_we    = upd_go && upd_prev_we;
      next_we    = upd_go && upd_next_we;
      prev_waddr = succ[IDX_W-1:0];
      next_waddr = pred[IDX_W-1:0];
      prev_wdata = pred;
      next_wdata = succ;
    end
  end

  ilsr_link_mem u_prev_mem (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (rd_en),
    .raddr (rm_index),
    .rdata (pred)
  );

  ilsr_link_mem u_next_mem (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rm_index),
    .rdata (succ)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      index_count   <= COUNT_MAX;
      lowest        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (upd_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_wen) begin
        index_count <= (cfg_wdata > COUNT_MAX) ? COUNT_MAX : cfg_wdata;
        lowest      <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            rm_index   <= s_axis_tdata[IDX_W-1:0];
            rm_invalid <= {1'b0, s_axis_tdata[IDX_W-1:0]} >= index_count;
            state      <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (upd_go) begin
            lowest        <= lowest_next;
            m_axis_tdata  <= M_TDATA_W'({rm_invalid, lowest_next >= index_count,
                                         lowest_next});
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks index_linked_set_removal against a predictor of the link tables.
// A table of directed items and count writes runs first. It is followed by
// random episodes, and each episode writes a count and then removes the
// present indices in random order, with stray and repeated indices mixed in.
// Every result is compared field by field with the oldest prediction, under
// three idling patterns on the input and output streams.
// ----------------------------------------------------------------------------
module testbench
  import ilsr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 483;
  localparam int SETTLE       = 6;
  localparam int NUM_DIRECTED = 26;

  typedef struct packed {
    logic [LINK_W-1:0] lowest;
    logic              empty;
    logic              invalid;
  } removal_result_t;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [LINK_W-1:0] value;
    logic              has_want;
    logic [LINK_W-1:0] want_lowest;
    logic              want_empty;
    logic              want_invalid;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_wen = 1'b0;
  logic [LINK_W-1:0]    cfg_wdata = '0;

  logic [LINK_W-1:0] prev_tbl [MAX_INDICES];
  logic [LINK_W-1:0] next_tbl [MAX_INDICES];
  logic [LINK_W-1:0] lowest_live;
  logic [LINK_W-1:0] live_count;

  removal_result_t pending_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_ITEM,  11'd0,    1'b1, 11'd1, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1023, 1'b1, 11'd1, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1,    1'b1, 11'd2, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd5,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1023, 1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd2,    1'b1, 11'd3, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd4,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_COUNT, 11'd0,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd0,    1'b1, 11'd0, 1'b1, 1'b1},
    '{ROW_ITEM,  11'd1023, 1'b1, 11'd0, 1'b1, 1'b1},
    '{ROW_COUNT, 11'd1,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd0,    1'b1, 11'd1, 1'b1, 1'b0},
    '{ROW_ITEM,  11'd0,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1,    1'b1, 11'd1, 1'b1, 1'b1},
    '{ROW_COUNT, 11'd2047, 1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1023, 1'b1, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd0,    1'b1, 11'd1, 1'b0, 1'b0},
    '{ROW_COUNT, 11'd3,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1,    1'b1, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd0,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd2,    1'b1, 11'd3, 1'b1, 1'b0},
    '{ROW_ITEM,  11'd512,  1'b1, 11'd3, 1'b1, 1'b1},
    '{ROW_ITEM,  11'd2,    1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_COUNT, 11'd1024, 1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd512,  1'b0, 11'd0, 1'b0, 1'b0},
    '{ROW_ITEM,  11'd1022, 1'b0, 11'd0, 1'b0, 1'b0}
  };

  index_linked_set_removal DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic rebuild_links(input logic [LINK_W-1:0] wdata);
    live_count = (wdata > COUNT_MAX) ? COUNT_MAX : wdata;
    for (int i = 0; i < MAX_INDICES; i++) begin
      prev_tbl[i] = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
      next_tbl[i] = LINK_W'(i + 1);
    end
    lowest_live = '0;
  endtask

  task automatic apply_removal(input logic [IDX_W-1:0] idx, output removal_result_t res);
    logic [LINK_W-1:0] m;
    logic [LINK_W-1:0] pred;
    logic [LINK_W-1:0] succ;
    m = LINK_W'(idx);
    res.invalid = 1'b0;
    if (m >= live_count) begin
      res.invalid = 1'b1;
    end else if (m == lowest_live) begin
      succ = next_tbl[idx];
      lowest_live = succ;
      if (succ < live_count) prev_tbl[succ[IDX_W-1:0]] = prev_tbl[idx];
    end else begin
      pred = prev_tbl[idx];
      succ = next_tbl[idx];
      if (pred < live_count) next_tbl[pred[IDX_W-1:0]] = succ;
      if (succ < live_count) prev_tbl[succ[IDX_W-1:0]] = pred;
    end
    res.lowest = lowest_live;
    res.empty  = (lowest_live >= live_count);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input logic [IDX_W-1:0] idx, input bit hold_off,
                           input bit has_want, input removal_result_t want);
    int gap;
    removal_result_t res;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (hold_off && gap == 0) gap = 1;
    if (hold_off || gap > 0) begin
      s_axis_tvalid <= 1'b0;
      if (hold_off) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(idx);
    do @(posedge clk); while (!s_axis_tready);
    apply_removal(idx, res);
    pending_results.push_back(has_want ? want : res);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [LINK_W-1:0] wdata);
    cfg_wen   <= 1'b1;
    cfg_wdata <= wdata;
    @(posedge clk);
    rebuild_links(wdata);
    cfg_wen <= 1'b0;
  endtask

  task automatic run_episode(input int phase_end);
    int sel;
    int n;
    int cap;
    int j;
    int pick;
    logic [LINK_W-1:0] wval;
    int present [$];
    int gone [$];
    sel = $urandom_range(0, 99);
    if (sel < 8) wval = '0;
    else if (sel < 15) wval = COUNT_MAX;
    else if (sel < 20) wval = LINK_W'($urandom_range(1025, 2047));
    else if (sel < 30) wval = LINK_W'($urandom_range(49, 1023));
    else wval = LINK_W'($urandom_range(1, 48));
    wait_idle();
    write_count(wval);
    n = (wval > COUNT_MAX) ? MAX_INDICES : int'(wval);
    for (j = 0; j < n; j++) present.push_back(j);
    cap = (n > 48) ? $urandom_range(16, 64) : n + $urandom_range(1, 4);
    for (int k = 0; k < cap && items_sent < phase_end; k++) begin
      if (present.size() == 0 || $urandom_range(0, 99) < 15) begin
        if (n < MAX_INDICES && $urandom_range(0, 1) == 1) pick = $urandom_range(n, 1023);
        else if (gone.size() > 0 && $urandom_range(0, 1) == 1)
          pick = gone[$urandom_range(0, gone.size() - 1)];
        else pick = $urandom_range(0, 1023);
      end else begin
        j = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(0, present.size() - 1);
        pick = present[j];
        present.delete(j);
        gone.push_back(pick);
      end
      send_item(pick[IDX_W-1:0], $urandom_range(0, 99) == 0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    removal_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", int'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[10:0] !== want.lowest)
          report_mismatch("lowest_present", int'(m_axis_tdata[10:0]), int'(want.lowest));
        if (m_axis_tdata[11] !== want.empty)
          report_mismatch("set_empty", int'(m_axis_tdata[11]), int'(want.empty));
        if (m_axis_tdata[12] !== want.invalid)
          report_mismatch("index_invalid", int'(m_axis_tdata[12]), int'(want.invalid));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    removal_result_t want;
    int phase_end;
    rebuild_links(COUNT_MAX);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 82;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_COUNT) begin
        wait_idle();
        write_count(directed_rows[r].value);
      end else begin
        want.lowest  = directed_rows[r].want_lowest;
        want.empty   = directed_rows[r].want_empty;
        want.invalid = directed_rows[r].want_invalid;
        send_item(directed_rows[r].value[IDX_W-1:0], 1'b0, directed_rows[r].has_want, want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 28 : 0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_episode(phase_end);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ilsr_pkg.sv
rtl/ilsr_link_mem.sv
rtl/ilsr_clear.sv
rtl/index_linked_set_removal.sv
tb/testbench.sv
